// ----- src/rsplb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the run-length sprite line blitter.
package rsplb_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int SCREEN_LIMIT    = 4096;
   localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   localparam logic [7:0] ROW_END = 8'hFF;

   localparam logic signed [17:0] POS_MAX = 18'sd131071;
   localparam logic signed [17:0] POS_MIN = -18'sd131072;
   localparam logic signed [19:0] SCREEN_LIM_S = 20'(SCREEN_LIMIT);

   // CSR indexes
   localparam logic [2:0] CSR_START_X     = 3'd0;
   localparam logic [2:0] CSR_START_Y     = 3'd1;
   localparam logic [2:0] CSR_CLIP_LEFT   = 3'd2;
   localparam logic [2:0] CSR_CLIP_RIGHT  = 3'd3;
   localparam logic [2:0] CSR_CLIP_TOP    = 3'd4;
   localparam logic [2:0] CSR_CLIP_BOTTOM = 3'd5;
   localparam logic [2:0] CSR_MIRROR      = 3'd6;

   localparam logic [12:0] CLIP_RIGHT_RST  = 13'd4096;
   localparam logic [12:0] CLIP_BOTTOM_RST = 13'd4096;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_VIS,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic [12:0]        clip_left;
      logic [12:0]        clip_right;
      logic [12:0]        clip_top;
      logic [12:0]        clip_bottom;
      logic               mirror;
   } cfg_type;

   typedef struct packed {
      logic       action;
      logic       sprite_start;
      logic       row_start;
      logic [7:0] sprite_byte;
   } item_type;

   typedef struct packed {
      logic        emit;
      logic [11:0] x;
      logic [11:0] y;
   } draw_type;

   // Saturate a position to the 18-bit signed range.
   function automatic logic signed [17:0] pos_hold(input logic signed [19:0] v);
      logic signed [17:0] r;
      if (v > 20'(POS_MAX))
         r = POS_MAX;
      else if (v < 20'(POS_MIN))
         r = POS_MIN;
      else
         r = v[17:0];
      return r;
   endfunction

   // Clip limit: min(clip, SCREEN_LIMIT) as a signed position.
   function automatic logic signed [19:0] clip_lim(input logic [12:0] c);
      logic signed [19:0] cs;
      cs = $signed({7'd0, c});
      return (cs < SCREEN_LIM_S) ? cs : SCREEN_LIM_S;
   endfunction

   // Palette address: byte modulo PALETTE_ENTRIES, as a constant table.
   function automatic logic [PAL_AW-1:0] pal_addr(input logic [7:0] v);
      logic [PAL_AW-1:0] r;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         if (v == 8'(i))
            r = PAL_AW'(i % PALETTE_ENTRIES);
      end
      return r;
   endfunction

endpackage

// ----- src/rle_sprite_line_blitter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the run-length sprite line blitter.
//
// Takes one word per cycle while not stalled: either a palette write (action
// 0) or one byte of a run-length encoded sprite row (action 1), and emits one
// pixel word (screen x, y and 16-bit palette color) for every byte that lands
// inside the clip rectangle. The block sustains one input word per clock
// unless a drawn pixel waits on a stalled rsp_ register. A word is registered
// on accept together with its palette read, decoded against the row state in
// the next cycle, and a drawn pixel is loaded into the rsp_ register when the
// word leaves the input register. The palette RAM's registered read port is
// what sets that input stage. The rsp_ output register decouples the two
// sides: a stalled pixel blocks only the next drawn pixel, while palette
// writes and bytes that draw nothing keep flowing. Registers are written
// through the csr_ port (always ready) and must only change while no word is
// in flight.
module rle_sprite_line_blitter_unit
   import rsplb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic        req_sprite_start,
   input  logic        req_row_start,
   input  logic [7:0]  req_sprite_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [15:0] req_palette_value,
   // pixel words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_pixel_x,
   output logic [11:0] rsp_pixel_y,
   output logic [15:0] rsp_color,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type     cfg_ff;
   item_type    item_ff;
   logic        s1_valid_ff;
   logic        out_valid_ff;
   logic [11:0] out_x_ff, out_y_ff;
   logic [15:0] out_color_ff;
   logic [15:0] pal_rd_data;
   draw_type    draw;
   logic        req_accept, s1_go, out_free;

   // ---- configuration registers ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x     <= '0;
         cfg_ff.start_y     <= '0;
         cfg_ff.clip_left   <= '0;
         cfg_ff.clip_right  <= CLIP_RIGHT_RST;
         cfg_ff.clip_top    <= '0;
         cfg_ff.clip_bottom <= CLIP_BOTTOM_RST;
         cfg_ff.mirror      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_X:     cfg_ff.start_x     <= csr_data;
            CSR_START_Y:     cfg_ff.start_y     <= csr_data;
            CSR_CLIP_LEFT:   cfg_ff.clip_left   <= csr_data[12:0];
            CSR_CLIP_RIGHT:  cfg_ff.clip_right  <= csr_data[12:0];
            CSR_CLIP_TOP:    cfg_ff.clip_top    <= csr_data[12:0];
            CSR_CLIP_BOTTOM: cfg_ff.clip_bottom <= csr_data[12:0];
            CSR_MIRROR:      cfg_ff.mirror      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---- handshake ----
   // Stage 1 moves on unless it draws a pixel and the output register is held.
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_go      = s1_valid_ff && (!draw.emit || out_free);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   // ---- palette: write and read both happen on accept ----
   rsplb_palette u_palette (
      .clock   (clock),
      .wr_en   (req_accept && !req_action),
      .wr_addr (pal_addr(req_palette_index)),
      .wr_data (req_palette_value),
      .rd_en   (req_accept && req_action),
      .rd_addr (pal_addr(req_sprite_byte)),
      .rd_data (pal_rd_data)
   );

   // ---- input register ----
   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (req_accept)
         s1_valid_ff <= 1'b1;
      else if (s1_go)
         s1_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.action       <= req_action;
         item_ff.sprite_start <= req_sprite_start;
         item_ff.row_start    <= req_row_start;
         item_ff.sprite_byte  <= req_sprite_byte;
      end
   end

   // ---- row decode ----
   rsplb_row_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_go),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .draw    (draw)
   );

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (s1_go && draw.emit)
         out_valid_ff <= 1'b1;
      else if (!rsp_stall)
         out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (s1_go && draw.emit) begin
         out_x_ff     <= draw.x;
         out_y_ff     <= draw.y;
         out_color_ff <= pal_rd_data;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_pixel_x = out_x_ff;
   assign rsp_pixel_y = out_y_ff;
   assign rsp_color   = out_color_ff;

endmodule

// ----- src/rsplb_palette.sv -----
`timescale 1ns / 1ps
// Palette memory: one write port, one registered read port.
module rsplb_palette
   import rsplb_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [PAL_AW-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [PAL_AW-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [PALETTE_ENTRIES];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rsplb_row_decoder.sv -----
`timescale 1ns / 1ps
// Row state and per-byte decode: skip/visible/data phases with clipping.
module rsplb_row_decoder
   import rsplb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  item_type item,
   input  cfg_type  cfg,
   output draw_type draw
);

   logic signed [17:0] cursor_x_ff, cursor_x_in;
   logic signed [17:0] row_y_ff, row_y_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         lead_left_ff, lead_left_in;
   logic [7:0]         draw_left_ff, draw_left_in;
   logic               row_done_ff, row_done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         row_y_ff     <= '0;
         phase_ff     <= PH_SKIP;
         lead_left_ff <= '0;
         draw_left_ff <= '0;
         row_done_ff  <= 1'b1;
      end else if (advance) begin
         cursor_x_ff  <= cursor_x_in;
         row_y_ff     <= row_y_in;
         phase_ff     <= phase_in;
         lead_left_ff <= lead_left_in;
         draw_left_ff <= draw_left_in;
         row_done_ff  <= row_done_in;
      end
   end

   always_comb begin : decode
      logic signed [19:0] cx, cnt, lead, xmin, xmax, ymax, ytop, ry, bs;
      logic               fin, pair_end;
      phase_type          ph;
      xmin     = $signed({7'd0, cfg.clip_left});
      xmax     = clip_lim(cfg.clip_right);
      ymax     = clip_lim(cfg.clip_bottom);
      ytop     = $signed({7'd0, cfg.clip_top});
      bs       = $signed({12'd0, item.sprite_byte});
      cx       = 20'(cursor_x_ff);
      ry       = 20'(row_y_ff);
      cnt      = '0;
      lead     = '0;
      fin      = row_done_ff;
      pair_end = 1'b0;
      ph       = phase_ff;

      row_y_in     = row_y_ff;
      phase_in     = phase_ff;
      lead_left_in = lead_left_ff;
      draw_left_in = draw_left_ff;
      draw         = '0;

      if (item.action) begin
         // Row start: reload cursor, clear counters, check the row can draw at all.
         if (item.sprite_start || item.row_start) begin
            if (item.sprite_start)
               row_y_in = 18'(cfg.start_y);
            else if (row_y_ff != POS_MAX)
               row_y_in = row_y_ff + 18'sd1;
            cx           = 20'(cfg.start_x);
            lead_left_in = '0;
            draw_left_in = '0;
            fin          = 1'b0;
            pair_end     = 1'b1;
         end
         if (pair_end) begin
            phase_in = PH_SKIP;
            ph       = PH_SKIP;
            fin      = cfg.mirror ? !(cx > xmin) : !(cx < xmax);
            pair_end = 1'b0;
         end

         // The byte that opens a row is also that row's first skip count.
         if (!fin) begin
            unique case (ph)
               PH_SKIP: begin
                  if (item.sprite_byte == ROW_END) begin
                     fin = 1'b1;
                  end else if (cfg.mirror) begin
                     cx = 20'(pos_hold(cx - bs));
                     if (cx <= xmin) fin = 1'b1;
                     else            phase_in = PH_VIS;
                  end else begin
                     cx = 20'(pos_hold(cx + bs));
                     if (cx >= xmax) fin = 1'b1;
                     else            phase_in = PH_VIS;
                  end
               end
               PH_VIS: begin
                  cnt = bs;
                  if (cnt == 20'sd0) begin
                     pair_end = 1'b1;
                  end else begin
                     if (cfg.mirror) begin
                        if (cx - cnt >= xmax) begin
                           lead = cnt;
                           cnt  = '0;
                           cx   = 20'(pos_hold(cx - bs));
                        end else begin
                           if (cx > xmax) begin
                              lead = cx - xmax;
                              cnt  = cnt - lead;
                              cx   = xmax;
                           end
                           if (cx - cnt < xmin) cnt = cx - xmin;
                        end
                     end else begin
                        if (cx + cnt <= xmin) begin
                           lead = cnt;
                           cnt  = '0;
                           cx   = 20'(pos_hold(cx + bs));
                        end else begin
                           if (cx < xmin) begin
                              lead = xmin - cx;
                              cnt  = cnt - lead;
                              cx   = xmin;
                           end
                           if (cx + cnt > xmax) cnt = xmax - cx;
                        end
                     end
                     if (cnt < 20'sd0) cnt = '0;
                     lead_left_in = lead[7:0];
                     draw_left_in = cnt[7:0];
                     if (lead[7:0] == 8'd0 && cnt[7:0] == 8'd0)
                        pair_end = 1'b1;
                     else
                        phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (lead_left_ff != 8'd0) begin
                     lead_left_in = lead_left_ff - 8'd1;
                     if (lead_left_in == 8'd0 && draw_left_ff == 8'd0)
                        pair_end = 1'b1;
                  end else if (draw_left_ff == 8'd0) begin
                     pair_end = 1'b1;
                  end else begin
                     if (cfg.mirror) begin
                        cx     = 20'(pos_hold(cx - 20'sd1));
                        draw.x = cx[11:0];
                     end else begin
                        draw.x = cx[11:0];
                        cx     = 20'(pos_hold(cx + 20'sd1));
                     end
                     draw_left_in = draw_left_ff - 8'd1;
                     draw.y       = row_y_ff[11:0];
                     draw.emit    = (ry >= ytop) && (ry < ymax);
                     if (draw_left_in == 8'd0)
                        pair_end = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_SKIP;
               end
            endcase
            // End of a pair: continue only while the cursor is inside the window.
            if (pair_end) begin
               phase_in = PH_SKIP;
               if (cfg.mirror ? !(cx > xmin) : !(cx < xmax))
                  fin = 1'b1;
            end
         end
      end

      cursor_x_in = cx[17:0];
      row_done_in = fin;
   end

endmodule

// ----- src/rsplb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the sprite line blitter, bound to the top level.
module rsplb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_action,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_pixel_x,
   input logic [11:0] rsp_pixel_y,
   input logic [15:0] rsp_color
);

   // Pixel word is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // A held pixel word keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_color))
      else $error("stalled pixel word changed");

   // Input is held back only by a stalled pixel word.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled output");

   // A pixel word from an empty output traces to an accepted sprite byte.
   a_pixel_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_action, 2))
      else $error("pixel word without a sprite byte");

endmodule

bind rle_sprite_line_blitter_unit rsplb_checker u_rsplb_checker (.*);
